### src/transposition_table_probe_store_assert.svh
// Assertion macros for the transposition table probe and store block.
// Used by the top level of the block; no other dependencies.
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_ASSERT_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_ASSERT_SVH

`ifndef SYNTH
// A condition that must hold at every clock edge outside reset.
`define TTPS_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// A condition in one cycle that requires another in the next cycle.
`define TTPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TTPS_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define TTPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### src/ttps_pkg.sv
// Shared types and constants for the transposition table probe and store block.
// Used by every module of the block; depends on nothing.
package ttps_pkg;

   localparam int DEFAULT_INDEX_BITS = 10;
   localparam int KEY_W   = 64;
   localparam int DEPTH_W = 6;
   localparam int SCORE_W = 16;
   localparam int KIND_W  = 2;
   localparam int MOVE_W  = 24;

   typedef enum logic {
      CMD_PROBE = 1'b0,
      CMD_STORE = 1'b1
   } command_type;

   typedef enum logic [KIND_W-1:0] {
      BOUND_EXACT = 2'd0,
      BOUND_LOWER = 2'd1,
      BOUND_UPPER = 2'd2
   } bound_kind_type;

   typedef struct packed {
      logic                      command;
      logic [KEY_W-1:0]          key;
      logic [DEPTH_W-1:0]        depth;
      logic signed [SCORE_W-1:0] score;
      logic [KIND_W-1:0]         kind;
      logic [MOVE_W-1:0]         move;
      logic signed [SCORE_W-1:0] lower;
      logic signed [SCORE_W-1:0] upper;
      logic                      allow;
   } req_item_type;

   typedef struct packed {
      logic [KEY_W-1:0]          key;
      logic signed [SCORE_W-1:0] score;
      logic [KIND_W-1:0]         kind;
      logic [DEPTH_W-1:0]        depth;
      logic [MOVE_W-1:0]         move;
   } slot_data_type;

   typedef struct packed {
      logic          valid;
      slot_data_type data;
   } slot_entry_type;

   typedef struct packed {
      logic                      cutoff;
      logic signed [SCORE_W-1:0] cutoff_score;
      logic [MOVE_W-1:0]         slot_move;
      logic                      written;
   } rsp_item_type;

endpackage

### src/ttps_slot_ram.sv
// Slot storage: valid bits and entry data with registered reads, a clearing
// sweep of the valid bits after reset, and forwarding of the latest write. Uses ttps_pkg.
module ttps_slot_ram #(
   parameter int INDEX_BITS = ttps_pkg::DEFAULT_INDEX_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [INDEX_BITS-1:0]    rd_idx,
   input  logic                     wr_en,
   input  logic [INDEX_BITS-1:0]    wr_idx,
   input  ttps_pkg::slot_data_type  wr_data,
   output ttps_pkg::slot_entry_type rd_entry,
   output logic                     busy
);
   import ttps_pkg::*;

   localparam int SLOTS = 1 << INDEX_BITS;

   slot_data_type data_mem  [SLOTS];
   logic          valid_mem [SLOTS];

   slot_data_type           data_rd_ff;
   logic                    valid_rd_ff;
   logic [INDEX_BITS-1:0]   rd_idx_ff;
   logic                    fwd_valid_ff;
   logic [INDEX_BITS-1:0]   fwd_idx_ff;
   slot_data_type           fwd_data_ff;
   logic                    clr_busy_ff;
   logic [INDEX_BITS-1:0]   clr_idx_ff;
   logic [INDEX_BITS-1:0]   clr_idx_in;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_rd_ff  <= data_mem[rd_idx];
         valid_rd_ff <= valid_mem[rd_idx];
         rd_idx_ff   <= rd_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         data_mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         valid_mem[clr_idx_ff] <= 1'b0;
      end else if (wr_en) begin
         valid_mem[wr_idx] <= 1'b1;
      end
   end

   always_comb begin
      clr_idx_in = clr_idx_ff + INDEX_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_in;
         if (clr_idx_ff == '1) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // The read that shares an edge with a write sees old data, so the last
   // write is kept aside and replaces the read data when the slots match.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (wr_en) begin
         fwd_valid_ff <= 1'b1;
         fwd_idx_ff   <= wr_idx;
         fwd_data_ff  <= wr_data;
      end
   end

   always_comb begin
      if (fwd_valid_ff && (fwd_idx_ff == rd_idx_ff)) begin
         rd_entry.valid = 1'b1;
         rd_entry.data  = fwd_data_ff;
      end else begin
         rd_entry.valid = valid_rd_ff;
         rd_entry.data  = data_rd_ff;
      end
   end

   assign busy = clr_busy_ff;

endmodule

### src/ttps_decide.sv
// Probe and store decision for one word against the entry of its slot.
// Purely combinational; uses ttps_pkg.
module ttps_decide (
   input  ttps_pkg::req_item_type   item,
   input  ttps_pkg::slot_entry_type entry,
   output ttps_pkg::rsp_item_type   rsp,
   output logic                     replace
);
   import ttps_pkg::*;

   logic                      key_match;
   logic                      hit;
   logic                      kind_cut;
   logic signed [SCORE_W-1:0] stored_score;

   always_comb begin
      stored_score = entry.data.score;
      key_match    = (entry.data.key == item.key);
      hit          = entry.valid && item.allow && key_match && (entry.data.depth >= item.depth);

      case (entry.data.kind)
         BOUND_EXACT: kind_cut = 1'b1;
         BOUND_LOWER: kind_cut = (stored_score >= item.upper);
         BOUND_UPPER: kind_cut = (stored_score <= item.lower);
         default:     kind_cut = 1'b0;
      endcase

      rsp     = '0;
      replace = 1'b0;
      if (item.command == CMD_STORE) begin
         // Depth-preferred replacement, but a different position always wins.
         replace     = !entry.valid || (item.depth >= entry.data.depth) || !key_match;
         rsp.written = replace;
      end else begin
         rsp.slot_move = entry.valid ? entry.data.move : '0;
         if (hit && kind_cut) begin
            rsp.cutoff       = 1'b1;
            rsp.cutoff_score = stored_score;
         end
      end
   end

endmodule

### src/transposition_table_probe_store.sv
// Top level of the transposition table probe and store block.
// Depends on ttps_pkg, ttps_slot_ram, ttps_decide and the assertion macro header.
//
//   channel  direction  ports                 content
//   req      in         req_valid/req_ready   command, key, depth, score, kind, move, window
//   rsp      out        rsp_valid/rsp_ready   cutoff, cutoff score, slot move, written flag
//
// One word per cycle is accepted unless a stalled result or the valid sweep holds the input;
// its slot is read at acceptance into the middle stage, and the result is then registered
// in the result register. The single slot read-modify-write sets that rate; the last write is forwarded.
// After reset the valid bits of all 2**INDEX_BITS slots (1024 by default) are swept
// with req_ready low. A stalled result holds the stage behind it, and the input
// still accepts a word while the middle stage is free.
module transposition_table_probe_store #(
   parameter int INDEX_BITS = ttps_pkg::DEFAULT_INDEX_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic [ttps_pkg::KEY_W-1:0]          req_position_key,
   input  logic [ttps_pkg::DEPTH_W-1:0]        req_search_depth,
   input  logic signed [ttps_pkg::SCORE_W-1:0] req_entry_score,
   input  logic [ttps_pkg::KIND_W-1:0]         req_bound_kind,
   input  logic [ttps_pkg::MOVE_W-1:0]         req_best_move,
   input  logic signed [ttps_pkg::SCORE_W-1:0] req_lower_window,
   input  logic signed [ttps_pkg::SCORE_W-1:0] req_upper_window,
   input  logic                                req_probe_allowed,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_cutoff,
   output logic signed [ttps_pkg::SCORE_W-1:0] rsp_cutoff_score,
   output logic [ttps_pkg::MOVE_W-1:0]         rsp_slot_move,
   output logic                                rsp_written
);
   import ttps_pkg::*;
   `include "transposition_table_probe_store_assert.svh"

   req_item_type   req_item;
   req_item_type   s1_item_ff;
   logic           s1_valid_ff;
   logic           s1_valid_in;
   logic           s1_fire;
   logic           req_accept;
   rsp_item_type   rsp_ff;
   rsp_item_type   rsp_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   slot_entry_type entry;
   logic           replace;
   logic           ram_busy;
   logic           wr_en;
   slot_data_type  wr_data;

   always_comb begin
      req_item.command = req_command;
      req_item.key     = req_position_key;
      req_item.depth   = req_search_depth;
      req_item.score   = req_entry_score;
      req_item.kind    = req_bound_kind;
      req_item.move    = req_best_move;
      req_item.lower   = req_lower_window;
      req_item.upper   = req_upper_window;
      req_item.allow   = req_probe_allowed;
   end

   always_comb begin
      s1_fire      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready    = !ram_busy && (!s1_valid_ff || s1_fire);
      req_accept   = req_valid && req_ready;
      s1_valid_in  = req_accept || (s1_valid_ff && !s1_fire);
      rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_ready);
      wr_en        = s1_fire && replace;
      wr_data.key   = s1_item_ff.key;
      wr_data.score = s1_item_ff.score;
      wr_data.kind  = s1_item_ff.kind;
      wr_data.depth = s1_item_ff.depth;
      wr_data.move  = s1_item_ff.move;
   end

   ttps_slot_ram #(
      .INDEX_BITS (INDEX_BITS)
   ) u_slot_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_idx   (req_position_key[INDEX_BITS-1:0]),
      .wr_en    (wr_en),
      .wr_idx   (s1_item_ff.key[INDEX_BITS-1:0]),
      .wr_data  (wr_data),
      .rd_entry (entry),
      .busy     (ram_busy)
   );

   ttps_decide u_decide (
      .item    (s1_item_ff),
      .entry   (entry),
      .rsp     (rsp_in),
      .replace (replace)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_item;
      end
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cutoff       = rsp_ff.cutoff;
   assign rsp_cutoff_score = rsp_ff.cutoff_score;
   assign rsp_slot_move    = rsp_ff.slot_move;
   assign rsp_written      = rsp_ff.written;

   `TTPS_ASSERT_ALWAYS(a_no_accept_in_sweep, clock, reset, !(req_accept && ram_busy), "word accepted during valid sweep")
   `TTPS_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, s1_fire, rsp_valid_ff, "finished word did not reach the result register")
   `TTPS_ASSERT_ALWAYS(a_write_only_store, clock, reset, !wr_en || (s1_item_ff.command == CMD_STORE), "slot write from a probe")
   `TTPS_ASSERT_ALWAYS(a_score_gated, clock, reset, !(rsp_valid_ff && !rsp_ff.cutoff) || (rsp_ff.cutoff_score == '0), "score without cutoff")
   `TTPS_ASSERT_ALWAYS(a_store_quiet, clock, reset, !(rsp_valid_ff && rsp_ff.written) || (!rsp_ff.cutoff && (rsp_ff.slot_move == '0)), "store result carries probe fields")

endmodule
